FILE: rtl/kms_pkg.sv
// Shared types and constants for the key matrix scanner.
// No dependencies; used by kms_frame, kms_decode and key_matrix_scanner.
package kms_pkg;

  // Fixed widths of the row sample, the key word and the column output.
  localparam int unsigned ROW_BITS = 5;
  localparam int unsigned KEY_BITS = 20;
  localparam int unsigned COL_OUT_BITS = 2;
  localparam int unsigned FN_KEYS = 4;
  localparam int unsigned NUM_BITS = 4;

  // Key bit positions of the four function keys.
  localparam int unsigned FN_POS [FN_KEYS] = '{4, 9, 14, 19};

  // Number mapped to each key bit; function key bits map to zero.
  localparam logic [NUM_BITS-1:0] NUM_TABLE [KEY_BITS] = '{
    4'd12, 4'd8,  4'd4, 4'd0, 4'd0,
    4'd13, 4'd9,  4'd5, 4'd1, 4'd0,
    4'd14, 4'd10, 4'd6, 4'd2, 4'd0,
    4'd15, 4'd11, 4'd7, 4'd3, 4'd0
  };

  // Frame state after one sample has been folded in.
  typedef struct packed {
    logic [COL_OUT_BITS-1:0] next_column;
    logic                    frame_done;
    logic [KEY_BITS-1:0]     cur_frame;
    logic [KEY_BITS-1:0]     prev_frame;
  } kms_frame_t;

endpackage

FILE: rtl/kms_frame.sv
// Column counter, scan word and frame registers of the key matrix scanner.
// Depends on kms_pkg.
module kms_frame #(
  parameter int unsigned NUM_COLUMNS = 4,
  parameter int unsigned NUM_ROWS    = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  logic [kms_pkg::ROW_BITS-1:0]         row_levels_i,
  output kms_pkg::kms_frame_t                  frame_o
);
  import kms_pkg::*;

  localparam int unsigned ColW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [ROW_BITS-1:0] RowMask = ROW_BITS'((1 << NUM_ROWS) - 1);
  localparam logic [ColW-1:0] LastCol = ColW'(NUM_COLUMNS - 1);

  logic [ColW-1:0]     col_q, col_d;
  logic [KEY_BITS-1:0] scan_q, scan_d;
  logic [KEY_BITS-1:0] cur_q, cur_d;
  logic [KEY_BITS-1:0] prev_q, prev_d;
  logic [ROW_BITS-1:0] pressed;
  logic [5:0]          shift;
  logic [63:0]         placed;
  logic [KEY_BITS-1:0] merged;
  logic                wrap;

  // Place the inverted row sample at the bit offset of the driven column.
  assign pressed = ~row_levels_i & RowMask;
  assign shift   = 6'(col_q) * 6'(NUM_ROWS);
  assign placed  = 64'(pressed) << shift;
  assign merged  = scan_q | placed[KEY_BITS-1:0];
  assign wrap    = (col_q == LastCol);

  // On the last column the frame closes and the scan word starts over.
  always_comb begin
    if (wrap) begin
      col_d  = '0;
      scan_d = '0;
      cur_d  = merged;
      prev_d = cur_q;
    end else begin
      col_d  = col_q + ColW'(1);
      scan_d = merged;
      cur_d  = cur_q;
      prev_d = prev_q;
    end
  end

  assign frame_o.next_column = COL_OUT_BITS'(col_d);
  assign frame_o.frame_done  = wrap;
  assign frame_o.cur_frame   = cur_d;
  assign frame_o.prev_frame  = prev_d;

  // State registers advance once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      scan_q <= '0;
      cur_q  <= '0;
      prev_q <= '0;
    end else if (advance_i) begin
      col_q  <= col_d;
      scan_q <= scan_d;
      cur_q  <= cur_d;
      prev_q <= prev_d;
    end
  end

endmodule

FILE: rtl/kms_decode.sv
// Function key masks and number key encoder of the key matrix scanner.
// Depends on kms_pkg.
module kms_decode (
  input  logic [kms_pkg::KEY_BITS-1:0] cur_frame_i,
  input  logic [kms_pkg::KEY_BITS-1:0] prev_frame_i,
  output logic [kms_pkg::FN_KEYS-1:0]  fn_keys_down_o,
  output logic [kms_pkg::FN_KEYS-1:0]  fn_keys_new_o,
  output logic [kms_pkg::NUM_BITS-1:0] number_key_o,
  output logic                         number_key_valid_o
);
  import kms_pkg::*;

  logic [KEY_BITS-1:0] fn_mask;

  // Function keys: held in this frame, and new when absent in the last one.
  always_comb begin
    fn_mask = '0;
    for (int k = 0; k < FN_KEYS; k++) begin
      fn_keys_down_o[k] = cur_frame_i[FN_POS[k]];
      fn_keys_new_o[k]  = cur_frame_i[FN_POS[k]] & ~prev_frame_i[FN_POS[k]];
      fn_mask[FN_POS[k]] = 1'b1;
    end
  end

  // Lowest pressed key bit that is not a function key wins; scanning down lets it override.
  always_comb begin
    number_key_o       = '0;
    number_key_valid_o = 1'b0;
    for (int k = KEY_BITS - 1; k >= 0; k--) begin
      if (cur_frame_i[k] && !fn_mask[k]) begin
        number_key_o       = NUM_TABLE[k];
        number_key_valid_o = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/key_matrix_scanner.sv
// Top level of the key matrix scanner: input register, frame state, result register.
// Depends on kms_pkg, kms_frame and kms_decode.
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o   row_levels_i
// result    out        out_valid_o / out_stall_i next_column_o, frame_done_o, key_state_o,
//                                               fn_keys_down_o, fn_keys_new_o, number_key_o,
//                                               number_key_valid_o
//
// One transaction in, one result out; an accepted input transaction passes the input register,
// then the result register. A new sample is taken every cycle unless in_stall_o holds the input;
// throughput is set by the frame state update, one sample per cycle as the input register drains.
// Reset clears the column counter, scan word and both frames.
// A stall on the result side holds the result register, then the input register.
module key_matrix_scanner #(
  parameter int unsigned NUM_COLUMNS = 4,
  parameter int unsigned NUM_ROWS    = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [kms_pkg::ROW_BITS-1:0]         row_levels_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [kms_pkg::COL_OUT_BITS-1:0]     next_column_o,
  output logic                                 frame_done_o,
  output logic [kms_pkg::KEY_BITS-1:0]         key_state_o,
  output logic [kms_pkg::FN_KEYS-1:0]          fn_keys_down_o,
  output logic [kms_pkg::FN_KEYS-1:0]          fn_keys_new_o,
  output logic [kms_pkg::NUM_BITS-1:0]         number_key_o,
  output logic                                 number_key_valid_o
);
  import kms_pkg::*;

  logic                s1_valid_q;
  logic [ROW_BITS-1:0] row_q;
  logic                out_ready;
  logic                s1_adv;
  kms_frame_t          frame;
  logic [FN_KEYS-1:0]  fn_down, fn_new;
  logic [NUM_BITS-1:0] num;
  logic                num_valid;

  logic                    out_valid_q;
  logic [COL_OUT_BITS-1:0] next_column_q;
  logic                    frame_done_q;
  logic [KEY_BITS-1:0]     key_state_q;
  logic [FN_KEYS-1:0]      fn_down_q, fn_new_q;
  logic [NUM_BITS-1:0]     num_q;
  logic                    num_valid_q;

  // Flow control between the two register stages.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      row_q <= row_levels_i;
    end
  end

  kms_frame #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_ROWS   (NUM_ROWS)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_adv),
    .row_levels_i(row_q),
    .frame_o     (frame)
  );

  kms_decode u_decode (
    .cur_frame_i       (frame.cur_frame),
    .prev_frame_i      (frame.prev_frame),
    .fn_keys_down_o    (fn_down),
    .fn_keys_new_o     (fn_new),
    .number_key_o      (num),
    .number_key_valid_o(num_valid)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      next_column_q <= frame.next_column;
      frame_done_q  <= frame.frame_done;
      key_state_q   <= frame.cur_frame;
      fn_down_q     <= fn_down;
      fn_new_q      <= fn_new;
      num_q         <= num;
      num_valid_q   <= num_valid;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_column_o      = next_column_q;
  assign frame_done_o       = frame_done_q;
  assign key_state_o        = key_state_q;
  assign fn_keys_down_o     = fn_down_q;
  assign fn_keys_new_o      = fn_new_q;
  assign number_key_o       = num_q;
  assign number_key_valid_o = num_valid_q;

endmodule
